### hw/rtl/lkv_pkg.sv
// lkv_pkg: shared types and codes for the lru key-value cache
// request and response word layouts, operation codes, per-cell update commands
// no dependencies
`default_nettype none

package lkv_pkg;

	// operation codes carried in the request word
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic        evicted;
		logic [31:0] evicted_key;
	} rsp_t;

	// update broadcast to every cell
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_PROMOTE,
		UPD_FILL,
		UPD_REMOVE
	} upd_t;

	typedef struct packed {
		logic        en;
		upd_t        kind;
		logic        write_value;
		logic [31:0] key;
		logic [31:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/lkv_cell.sv
// lkv_cell: one entry of the cache with its key compare and recency update
// depends on lkv_pkg
`default_nettype none

module lkv_cell #(
	parameter int CAPACITY = 16,
	localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lkv_pkg::cell_cmd_t    cmd,
	input  wire logic                  sel,
	input  wire logic [RANK_W-1:0]     ref_rank,
	output logic                       hit,
	output logic                       victim,
	output logic                       free,
	output logic [31:0]                hit_value,
	output logic [RANK_W-1:0]          hit_rank,
	output logic [31:0]                victim_key
);

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(CAPACITY - 1);

	logic              valid_q;
	logic [31:0]       key_q;
	logic [31:0]       value_q;
	logic [RANK_W-1:0] rank_q;

	assign hit        = valid_q && (key_q == cmd.key);
	assign victim     = valid_q && (rank_q == RANK_MAX);
	assign free       = !valid_q;
	assign hit_value  = hit ? value_q : 32'd0;
	assign hit_rank   = hit ? rank_q : '0;
	assign victim_key = victim ? key_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en) begin
			case (cmd.kind)
				lkv_pkg::UPD_FILL: begin
					if (sel) begin
						valid_q <= 1'b1;
					end
				end
				lkv_pkg::UPD_REMOVE: begin
					if (hit) begin
						valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			case (cmd.kind)
				lkv_pkg::UPD_PROMOTE: begin
					if (hit) begin
						rank_q <= '0;
						if (cmd.write_value) begin
							value_q <= cmd.value;
						end
					end else if (valid_q && rank_q < ref_rank) begin
						rank_q <= rank_q + RANK_W'(1);
					end
				end
				lkv_pkg::UPD_FILL: begin
					if (sel) begin
						key_q   <= cmd.key;
						value_q <= cmd.value;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + RANK_W'(1);
					end
				end
				lkv_pkg::UPD_REMOVE: begin
					if (!hit && valid_q && rank_q > ref_rank) begin
						rank_q <= rank_q - RANK_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level of the fully associative lru key-value cache
// depends on lkv_pkg and lkv_cell
`default_nettype none

// A fully associative store of CAPACITY key/value entries in least recently
// used order. Each request word is an insert, lookup or remove; each gives
// exactly one response word, in order. The block takes one request per clock
// cycle while the response register is free or being taken; while a response
// is stalled, a request waits in the input register and req_stall holds the
// next one. A request passes the input register, then the update in which every
// cell compares its key and updates its recency rank in parallel, loading the
// response register. That one update per request sets the rate: the next
// request reads the state that the previous one left. Reset clears the valid
// bits of all cells at once, so the block is ready with no clearing sweep.
module lru_key_value_cache #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lkv_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lkv_pkg::rsp_t      rsp
);

	localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// input register
	logic          vld_s1;
	lkv_pkg::req_t req_s1;

	// response register
	logic          rsp_vld_q;
	lkv_pkg::rsp_t rsp_q;

	logic advance;
	logic go;

	// per-cell results
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY-1:0] victim_v;
	logic [CAPACITY-1:0] free_v;
	logic [CAPACITY-1:0] sel_v;
	logic [31:0]         hit_value_v  [CAPACITY];
	logic [RANK_W-1:0]   hit_rank_v   [CAPACITY];
	logic [31:0]         victim_key_v [CAPACITY];

	// reductions over cells
	logic              any_hit;
	logic              full;
	logic [31:0]       hit_value;
	logic [RANK_W-1:0] hit_rank;
	logic [31:0]       victim_key;
	logic [CAPACITY-1:0] low_free;

	lkv_pkg::cell_cmd_t cmd;
	lkv_pkg::rsp_t      rsp_d;

	// the response register frees up when empty or being taken
	assign advance   = !rsp_vld_q || !rsp_stall;
	assign go        = vld_s1 && advance;
	assign req_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// cell array
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lkv_cell #(
			.CAPACITY(CAPACITY)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.sel        (sel_v[i]),
			.ref_rank   (hit_rank),
			.hit        (hit_v[i]),
			.victim     (victim_v[i]),
			.free       (free_v[i]),
			.hit_value  (hit_value_v[i]),
			.hit_rank   (hit_rank_v[i]),
			.victim_key (victim_key_v[i])
		);
	end

	// at most one cell hits and at most one is the victim, so an or suffices
	always_comb begin
		hit_value  = 32'd0;
		hit_rank   = '0;
		victim_key = 32'd0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value  = hit_value | hit_value_v[i];
			hit_rank   = hit_rank | hit_rank_v[i];
			victim_key = victim_key | victim_key_v[i];
		end
	end

	assign any_hit  = |hit_v;
	assign full     = !(|free_v);
	// lowest-numbered free cell as a one-hot mask
	assign low_free = free_v & (~free_v + CAPACITY'(1));
	// a full store overwrites its least recently used cell
	assign sel_v    = full ? victim_v : low_free;

	// decode the request into the cell update and the response
	always_comb begin
		cmd             = '0;
		cmd.en          = go;
		cmd.kind        = lkv_pkg::UPD_NONE;
		cmd.key         = req_s1.key;
		cmd.value       = req_s1.value;
		rsp_d           = '0;
		case (req_s1.op)
			lkv_pkg::OP_INSERT: begin
				rsp_d.found = any_hit;
				if (any_hit) begin
					cmd.kind        = lkv_pkg::UPD_PROMOTE;
					cmd.write_value = 1'b1;
				end else begin
					cmd.kind          = lkv_pkg::UPD_FILL;
					rsp_d.evicted     = full;
					rsp_d.evicted_key = full ? victim_key : 32'd0;
				end
			end
			lkv_pkg::OP_LOOKUP: begin
				rsp_d.found      = any_hit;
				rsp_d.read_value = hit_value;
				if (any_hit) begin
					cmd.kind = lkv_pkg::UPD_PROMOTE;
				end
			end
			lkv_pkg::OP_REMOVE: begin
				rsp_d.found = any_hit;
				if (any_hit) begin
					cmd.kind = lkv_pkg::UPD_REMOVE;
				end
			end
			default: ; // unused code: no change, zero response
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (go) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/lkv_checker.sv
// lkv_checker: port-level assertions for lru_key_value_cache, with its bind
// depends on lkv_pkg and lru_key_value_cache
`default_nettype none

module lkv_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire lkv_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire lkv_pkg::rsp_t rsp
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// an eviction only happens on an insert that missed
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> !rsp.found)
		else $error("eviction reported on a hit");

	// evicted key and read value are zero unless their flag is set
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.evicted || rsp.evicted_key == 32'd0)
			&& (rsp.found || rsp.read_value == 32'd0))
		else $error("response field set without its flag");

	// a word accepted while no response is valid is answered through the input and response registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
		else $error("response missing after accepted request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
